// ----- design/grbs_pkg.sv -----
// ----------------------------------------------------------------------------
// grbs_pkg
// Shared types and constants for the glyph row rasterizer with blank
// suppression: action codes, controller states, command and status bundles.
// ----------------------------------------------------------------------------
package grbs_pkg;

  localparam int FONT_AW    = 13;
  localparam int FONT_BYTES = 1 << FONT_AW;
  localparam int GLYPH_AW   = 7;
  localparam int GLYPHS     = 1 << GLYPH_AW;

  localparam logic [6:0] MAX_GLYPH_WIDTH = 7'd64;

  localparam logic [7:0] GLYPH_ROWS_RST = 8'd16;
  localparam logic [9:0] ROW_WIDTH_RST  = 10'd8;

  // configuration register indexes
  localparam logic CFG_GLYPH_ROWS = 1'b0;
  localparam logic CFG_ROW_WIDTH  = 1'b1;

  // result kinds
  localparam logic KIND_MARK    = 1'b0;
  localparam logic KIND_NEWLINE = 1'b1;

  typedef enum logic [1:0] {
    ACT_WR_BYTE  = 2'd0,
    ACT_WR_GLYPH = 2'd1,
    ACT_SCAN     = 2'd2,
    ACT_EOL      = 2'd3
  } action_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_LOOKUP,
    ST_FETCH,
    ST_SCAN,
    ST_FLUSH,
    ST_NEWLINE
  } state_t;

  typedef struct packed {
    logic take;     // request accepted this cycle
    logic look;     // evaluate glyph entry and row bounds
    logic step;     // consume one bitmap bit
    logic flush;    // send held mark as final result
    logic newline;  // send newline result
  } cmd_t;

  typedef struct packed {
    logic hit;      // glyph present and row inside bitmap
    logic wzero;    // glyph width is zero
    logic bit_set;  // current bitmap bit
    logic last_bit; // current bit is the last of the row
    logic held_v;   // a mark is held back for the last flag
    logic out_free; // output register can take a result
  } sts_t;

endpackage

// ----- design/grbs_ctrl.sv -----
// ----------------------------------------------------------------------------
// grbs_ctrl
// Sequencer for the rasterizer: accepts one request at a time and steps the
// datapath through lookup, bitmap fetch, bit scan and result flush or newline.
// ----------------------------------------------------------------------------
module grbs_ctrl (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_tvalid,
  output logic                in_tready,
  input  logic [1:0]          in_action,
  input  grbs_pkg::sts_t      sts,
  output grbs_pkg::cmd_t      cmd
);

  grbs_pkg::state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= grbs_pkg::ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    cmd       = '0;
    in_tready = 1'b0;
    case (state_r)
      grbs_pkg::ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.take = 1'b1;
          case (in_action)
            grbs_pkg::ACT_SCAN: state_nxt = grbs_pkg::ST_LOOKUP;
            grbs_pkg::ACT_EOL:  state_nxt = grbs_pkg::ST_NEWLINE;
            default:            state_nxt = grbs_pkg::ST_IDLE;
          endcase
        end
      end
      grbs_pkg::ST_LOOKUP: begin
        cmd.look = 1'b1;
        if (sts.hit && !sts.wzero) begin
          state_nxt = grbs_pkg::ST_FETCH;
        end else begin
          state_nxt = grbs_pkg::ST_IDLE;
        end
      end
      grbs_pkg::ST_FETCH: begin
        state_nxt = grbs_pkg::ST_SCAN;
      end
      grbs_pkg::ST_SCAN: begin
        // a set bit pushes the previously held mark out
        if (!(sts.bit_set && sts.held_v && !sts.out_free)) begin
          cmd.step = 1'b1;
          if (sts.last_bit) begin
            state_nxt = grbs_pkg::ST_FLUSH;
          end
        end
      end
      grbs_pkg::ST_FLUSH: begin
        if (!sts.held_v) begin
          state_nxt = grbs_pkg::ST_IDLE;
        end else if (sts.out_free) begin
          cmd.flush = 1'b1;
          state_nxt = grbs_pkg::ST_IDLE;
        end
      end
      grbs_pkg::ST_NEWLINE: begin
        if (sts.out_free) begin
          cmd.newline = 1'b1;
          state_nxt   = grbs_pkg::ST_IDLE;
        end
      end
      default: begin
        state_nxt = grbs_pkg::ST_IDLE;
      end
    endcase
  end

endmodule

// ----- design/grbs_dp.sv -----
// ----------------------------------------------------------------------------
// grbs_dp
// Datapath: font store, glyph table with valid bits, blank counter, bit
// scanner with one held mark, and the output register.
// ----------------------------------------------------------------------------
module grbs_dp (
  input  logic                clk,
  input  logic                rst_n,
  input  grbs_pkg::cmd_t      cmd,
  output grbs_pkg::sts_t      sts,
  input  logic [1:0]          in_action,
  input  logic [12:0]         byte_address,
  input  logic [7:0]          byte_value,
  input  logic [6:0]          char_code,
  input  logic [12:0]         glyph_offset,
  input  logic [7:0]          glyph_shift,
  input  logic [6:0]          glyph_width,
  input  logic [8:0]          row,
  input  logic [7:0]          glyph_rows,
  input  logic [9:0]          row_width_pixels,
  output logic                out_tvalid,
  input  logic                out_tready,
  output logic [15:0]         out_lead,
  output logic                out_kind,
  output logic                out_last
);

  typedef struct packed {
    logic [12:0] offset;
    logic [7:0]  shift;
    logic [6:0]  width;
  } glyph_t;

  function automatic logic [15:0] blank_add(input logic [15:0] p, input logic [6:0] n);
    logic [16:0] s;
    s = {1'b0, p} + {10'd0, n};
    return s[16] ? 16'hFFFF : s[15:0];
  endfunction

  logic [7:0]                    font_mem [grbs_pkg::FONT_BYTES];
  glyph_t                        tbl_mem  [grbs_pkg::GLYPHS];
  logic [grbs_pkg::GLYPHS-1:0]   gvld_r;
  glyph_t                        tbl_q_r;
  logic                          gvld_q_r;
  logic [7:0]                    font_q_r;
  logic [8:0]                    row_r;
  logic [12:0]                   addr_r, rd_addr;
  logic [6:0]                    cnt_r;
  logic [2:0]                    bit_r;
  logic [15:0]                   pending_r, pending_nxt;
  logic [15:0]                   held_r;
  logic                          held_v_r, held_v_nxt;
  logic                          out_v_r, out_v_nxt;
  logic [15:0]                   out_lead_r;
  logic                          out_kind_r, out_last_r;
  logic                          out_load;
  logic [15:0]                   load_lead;
  logic                          load_kind, load_last;
  glyph_t                        ent;
  glyph_t                        wr_ent;
  logic [9:0]                    line_w;
  logic                          in_rows, hit;
  logic [10:0]                   stride_sum;
  logic [7:0]                    stride;
  logic [15:0]                   prod;
  logic [12:0]                   base;
  logic                          bit_set;
  logic                          wr_glyph, wr_byte, rd_glyph;

  assign wr_byte  = cmd.take && (in_action == grbs_pkg::ACT_WR_BYTE);
  assign wr_glyph = cmd.take && (in_action == grbs_pkg::ACT_WR_GLYPH);
  assign rd_glyph = cmd.take && (in_action == grbs_pkg::ACT_SCAN);

  assign wr_ent.offset = glyph_offset;
  assign wr_ent.shift  = glyph_shift;
  assign wr_ent.width  = (glyph_width > grbs_pkg::MAX_GLYPH_WIDTH) ?
                         grbs_pkg::MAX_GLYPH_WIDTH : glyph_width;

  // next byte is read while the last bit of the current one is consumed
  assign rd_addr = (cmd.step && bit_r == 3'd7) ? addr_r + 13'd1 : addr_r;

  always_ff @(posedge clk) begin
    if (wr_byte) begin
      font_mem[byte_address] <= byte_value;
    end
    font_q_r <= font_mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (wr_glyph) begin
      tbl_mem[char_code] <= wr_ent;
    end
    if (rd_glyph) begin
      tbl_q_r <= tbl_mem[char_code];
      row_r   <= row;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gvld_r   <= '0;
      gvld_q_r <= 1'b0;
    end else begin
      if (wr_glyph) begin
        gvld_r[char_code] <= 1'b1;
      end
      if (rd_glyph) begin
        gvld_q_r <= gvld_r[char_code];
      end
    end
  end

  // entry lookup and row address
  assign ent        = gvld_q_r ? tbl_q_r : '0;
  assign line_w     = {1'b0, row_r} - {2'b00, ent.shift};
  assign in_rows    = !line_w[9] && (line_w[8:0] < {1'b0, glyph_rows});
  assign hit        = in_rows && (ent.offset != 13'd0);
  assign stride_sum = {1'b0, row_width_pixels} + 11'd7;
  assign stride     = stride_sum[10:3];
  assign prod       = stride * line_w[7:0];
  assign base       = ent.offset + prod[12:0];

  assign bit_set = font_q_r[~bit_r];

  always_ff @(posedge clk) begin
    if (cmd.look && hit) begin
      addr_r <= base;
      cnt_r  <= ent.width;
      bit_r  <= 3'd0;
    end else if (cmd.step) begin
      addr_r <= rd_addr;
      cnt_r  <= cnt_r - 7'd1;
      bit_r  <= bit_r + 3'd1;
    end
  end

  always_comb begin
    pending_nxt = pending_r;
    held_v_nxt  = held_v_r;
    out_load    = 1'b0;
    load_lead   = held_r;
    load_kind   = grbs_pkg::KIND_MARK;
    load_last   = 1'b0;
    if (cmd.look && !hit) begin
      pending_nxt = blank_add(pending_r, ent.width);
    end
    if (cmd.step) begin
      if (bit_set) begin
        out_load    = held_v_r;
        held_v_nxt  = 1'b1;
        pending_nxt = '0;
      end else begin
        pending_nxt = blank_add(pending_r, 7'd1);
      end
    end
    if (cmd.flush) begin
      out_load   = 1'b1;
      load_last  = 1'b1;
      held_v_nxt = 1'b0;
    end
    if (cmd.newline) begin
      out_load    = 1'b1;
      load_kind   = grbs_pkg::KIND_NEWLINE;
      load_lead   = '0;
      load_last   = 1'b1;
      pending_nxt = '0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.step && bit_set) begin
      held_r <= pending_r;
    end
  end

  assign out_v_nxt = out_load ? 1'b1 : (out_tready ? 1'b0 : out_v_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pending_r <= '0;
      held_v_r  <= 1'b0;
      out_v_r   <= 1'b0;
    end else begin
      pending_r <= pending_nxt;
      held_v_r  <= held_v_nxt;
      out_v_r   <= out_v_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_lead_r <= load_lead;
      out_kind_r <= load_kind;
      out_last_r <= load_last;
    end
  end

  assign out_tvalid = out_v_r;
  assign out_lead   = out_lead_r;
  assign out_kind   = out_kind_r;
  assign out_last   = out_last_r;

  assign sts.hit      = hit;
  assign sts.wzero    = (ent.width == 7'd0);
  assign sts.bit_set  = bit_set;
  assign sts.last_bit = (cnt_r == 7'd1);
  assign sts.held_v   = held_v_r;
  assign sts.out_free = !out_v_r || out_tready;

endmodule

// ----- design/glyph_row_rasterizer_blank_suppress_top.sv -----
// ----------------------------------------------------------------------------
// glyph_row_rasterizer_blank_suppress_top
// Bitmap font row rasterizer: turns glyph row scans into marks with leading
// blank counts and suppresses trailing blanks at end of line.
//
//   channel  | direction | handshake            | payload
//   ---------+-----------+----------------------+-----------------------------
//   in_      | input     | in_tvalid/in_tready  | in_tdata fields, in_tuser
//   out_     | output    | out_tvalid/out_tready| out_tdata, out_tuser, tlast
//   cfg_     | input     | cfg_wr_en            | cfg_index, cfg_wdata
//
// A row scan steps through lookup, fetch, scan and flush; an absent glyph or
// a blank row ends at lookup. The scan reads one bitmap bit per cycle while
// not stalled, from the single font store read port, so the rate is set by
// the glyph width. A stalled output holds the scan at the next set bit;
// reset is synchronous and clears the glyph table valid bits at once, with
// no clearing pass.
// ----------------------------------------------------------------------------
module glyph_row_rasterizer_blank_suppress_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  // byte_address, byte_value, char_code, glyph_offset, glyph_shift,
  // glyph_width, row, zero pad
  input  logic [71:0] in_tdata,
  // action
  input  logic [1:0]  in_tuser,
  output logic        out_tvalid,
  input  logic        out_tready,
  // lead_spaces
  output logic [15:0] out_tdata,
  // kind
  output logic        out_tuser,
  output logic        out_tlast,
  input  logic        cfg_wr_en,
  input  logic        cfg_index,
  input  logic [9:0]  cfg_wdata
);

  logic [7:0]      glyph_rows_r;
  logic [9:0]      row_width_r;
  grbs_pkg::cmd_t  cmd;
  grbs_pkg::sts_t  sts;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      glyph_rows_r <= grbs_pkg::GLYPH_ROWS_RST;
      row_width_r  <= grbs_pkg::ROW_WIDTH_RST;
    end else if (cfg_wr_en) begin
      case (cfg_index)
        grbs_pkg::CFG_GLYPH_ROWS: glyph_rows_r <= cfg_wdata[7:0];
        grbs_pkg::CFG_ROW_WIDTH:  row_width_r  <= cfg_wdata;
        default: ;
      endcase
    end
  end

  grbs_ctrl u_ctrl (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_action (in_tuser),
    .sts       (sts),
    .cmd       (cmd)
  );

  grbs_dp u_dp (
    .clk              (clk),
    .rst_n            (rst_n),
    .cmd              (cmd),
    .sts              (sts),
    .in_action        (in_tuser),
    .byte_address     (in_tdata[12:0]),
    .byte_value       (in_tdata[20:13]),
    .char_code        (in_tdata[27:21]),
    .glyph_offset     (in_tdata[40:28]),
    .glyph_shift      (in_tdata[48:41]),
    .glyph_width      (in_tdata[55:49]),
    .row              (in_tdata[64:56]),
    .glyph_rows       (glyph_rows_r),
    .row_width_pixels (row_width_r),
    .out_tvalid       (out_tvalid),
    .out_tready       (out_tready),
    .out_lead         (out_tdata),
    .out_kind         (out_tuser),
    .out_last         (out_tlast)
  );

endmodule

// ----- design/grbs_chk.sv -----
// ----------------------------------------------------------------------------
// grbs_chk
// Port-level checks for the rasterizer, bound to the top level.
// ----------------------------------------------------------------------------
module grbs_chk (
  input logic        clk,
  input logic        rst_n,
  input logic        in_tvalid,
  input logic        in_tready,
  input logic [1:0]  in_tuser,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [15:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // a newline is always the final and blank-free result of its request
  a_newline_form: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser == grbs_pkg::KIND_NEWLINE |-> out_tlast && out_tdata == 16'd0)
    else $error("newline result malformed");

  // end of line keeps the block busy while the newline is produced
  a_eol_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready && in_tuser == grbs_pkg::ACT_EOL |=> !in_tready)
    else $error("ready right after end of line request");

  // store writes finish in the cycle they are taken
  a_write_fast: assert property (@(posedge clk) disable iff (!rst_n)
    in_tvalid && in_tready &&
    (in_tuser == grbs_pkg::ACT_WR_BYTE || in_tuser == grbs_pkg::ACT_WR_GLYPH)
    |=> in_tready)
    else $error("write request held the input");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata) &&
    $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled result changed");

endmodule

bind glyph_row_rasterizer_blank_suppress_top grbs_chk u_grbs_chk (.*);
